/* rtl/core/spa_pkg.sv */
// Shared types, constants and arithmetic helpers for the sparse polynomial unit.
`default_nettype none
package spa_pkg;

  localparam int MAX_TERMS = 64;
  localparam int COEF_W    = 32;
  localparam int EXP_W     = 8;
  localparam int IDX_W     = $clog2(MAX_TERMS);
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int LIST_W    = 2;
  localparam int ADDR_W    = LIST_W + IDX_W;
  localparam int WORD_W    = COEF_W + EXP_W;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int FRAC_W    = 16;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_ADD    = 3'd2;
  localparam logic [2:0] CMD_MUL    = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;
  localparam logic [2:0] CMD_EVAL   = 3'd5;

  localparam logic [1:0] LIST_FIRST  = 2'd0;
  localparam logic [1:0] LIST_SECOND = 2'd1;
  localparam logic [1:0] LIST_RESULT = 2'd2;
  localparam logic [1:0] LIST_NONE   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam logic signed [COEF_W-1:0] C_HI  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] C_LO  = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] C_ONE = COEF_W'(1) << FRAC_W;

  typedef enum logic [4:0] {
    S_IDLE, S_DONE, S_RD_WAIT,
    S_AC_SCAN, S_AC_CMP, S_AC_INS, S_AC_UP, S_AC_UPW, S_AC_DEL, S_AC_DELW, S_AC_RET,
    S_AD_TOP, S_AD_RA, S_AD_RB,
    S_MU_TOP, S_MU_RA, S_MU_RB, S_MU_MUL, S_MU_SAT, S_MU_NEXT,
    S_EV_TOP, S_EV_LD, S_EV_BIT, S_EV_RMUL, S_EV_RSAT, S_EV_SHIFT,
    S_EV_BMUL, S_EV_BSAT, S_EV_TMUL, S_EV_TSAT
  } state_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] val;
    logic                     ovf;
  } sat_t;

  function automatic sat_t add_sat(input logic signed [COEF_W-1:0] a,
                                   input logic signed [COEF_W-1:0] b);
    logic signed [COEF_W:0] s;
    sat_t r;
    s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
    r.ovf = (s[COEF_W] != s[COEF_W-1]);
    if (!r.ovf) begin
      r.val = s[COEF_W-1:0];
    end else if (s[COEF_W]) begin
      r.val = C_LO;
    end else begin
      r.val = C_HI;
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] mk_addr(input logic [LIST_W-1:0] lst,
                                                input logic [CNT_W-1:0] idx);
    return {lst, idx[IDX_W-1:0]};
  endfunction

endpackage
`default_nettype wire

/* rtl/core/spa_mem.sv */
// Term store for all three lists: one write port, one registered read port.
`default_nettype none
module spa_mem (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [spa_pkg::ADDR_W-1:0] waddr,
  input  wire logic [spa_pkg::WORD_W-1:0] wdata,
  input  wire logic [spa_pkg::ADDR_W-1:0] raddr,
  output logic      [spa_pkg::WORD_W-1:0] rdata
);

  logic [spa_pkg::WORD_W-1:0] mem [(1 << spa_pkg::ADDR_W)];
  logic [spa_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/core/spa_mul.sv */
// Shared Q16.16 multiplier: registered magnitude product, then shift and saturate.
`default_nettype none
module spa_mul (
  input  wire logic                              clk,
  input  wire logic signed [spa_pkg::COEF_W-1:0] a,
  input  wire logic signed [spa_pkg::COEF_W-1:0] b,
  output spa_pkg::sat_t                          res
);

  logic [spa_pkg::COEF_W-1:0] ma;
  logic [spa_pkg::COEF_W-1:0] mb;
  logic [spa_pkg::PROD_W-1:0] prod_r;
  logic                       neg_r;
  logic [spa_pkg::PROD_W-spa_pkg::FRAC_W-1:0] q;

  assign ma = a[spa_pkg::COEF_W-1] ? spa_pkg::COEF_W'(-a) : a;
  assign mb = b[spa_pkg::COEF_W-1] ? spa_pkg::COEF_W'(-b) : b;

  always_ff @(posedge clk) begin
    prod_r <= spa_pkg::PROD_W'(ma) * spa_pkg::PROD_W'(mb);
    neg_r  <= a[spa_pkg::COEF_W-1] ^ b[spa_pkg::COEF_W-1];
  end

  // truncate magnitude toward zero, then clamp to the signed range
  assign q = prod_r[spa_pkg::PROD_W-1:spa_pkg::FRAC_W];

  always_comb begin
    res.ovf = 1'b0;
    res.val = '0;
    if (!neg_r) begin
      if (|q[$bits(q)-1:spa_pkg::COEF_W-1]) begin
        res.ovf = 1'b1;
        res.val = spa_pkg::C_HI;
      end else begin
        res.val = q[spa_pkg::COEF_W-1:0];
      end
    end else begin
      if ((|q[$bits(q)-1:spa_pkg::COEF_W]) ||
          (q[spa_pkg::COEF_W-1] && (|q[spa_pkg::COEF_W-2:0]))) begin
        res.ovf = 1'b1;
        res.val = spa_pkg::C_LO;
      end else begin
        res.val = -q[spa_pkg::COEF_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sparse_polynomial_arithmetic.sv */
// Throughput: one request at a time; in_ready is high only while the sequencer is idle.
// The term store has one read and one write port, and every list access goes through it;
// multiply and evaluate share the one multiplier. Reset (synchronous, rst_n low) empties all
// three lists and drops any pending result; term storage itself is not cleared.
`default_nettype none
module sparse_polynomial_arithmetic (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [2:0]                        in_command,
  input  wire logic [1:0]                        in_target,
  input  wire logic signed [spa_pkg::COEF_W-1:0] in_coefficient,
  input  wire logic [spa_pkg::EXP_W-1:0]         in_exponent,
  input  wire logic [spa_pkg::IDX_W-1:0]         in_term_index,
  input  wire logic signed [spa_pkg::COEF_W-1:0] in_point,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [spa_pkg::COEF_W-1:0]      out_coefficient,
  output logic [spa_pkg::EXP_W-1:0]              out_exponent,
  output logic [spa_pkg::CNT_W-1:0]              out_term_count,
  output logic signed [spa_pkg::COEF_W-1:0]      out_value,
  output logic                                   out_overflow,
  output logic [1:0]                             out_status
);

  localparam int CW = spa_pkg::COEF_W;
  localparam int EW = spa_pkg::EXP_W;
  localparam int NW = spa_pkg::CNT_W;

  spa_pkg::state_t state_r, state_nxt;

  // request being worked on
  logic [2:0]            cmd_r, cmd_nxt;
  logic [1:0]            tgt_r, tgt_nxt;
  logic [1:0]            lst_r, lst_nxt;
  logic signed [CW-1:0]  x_r, x_nxt;

  // list lengths: first, second, result
  logic [NW-1:0] cnt_r [3];
  logic [NW-1:0] cnt_nxt [3];

  // loop indexes: i/j walk the source lists, k the add output, s/m the accumulate
  logic [NW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, s_r, s_nxt, m_r, m_nxt;

  // operand holding registers
  logic signed [CW-1:0] a_c_r, a_c_nxt, b_c_r, b_c_nxt;
  logic [EW-1:0]        a_e_r, a_e_nxt;
  logic signed [CW-1:0] ac_c_r, ac_c_nxt;
  logic [EW-1:0]        ac_e_r, ac_e_nxt;
  logic signed [CW-1:0] acc_r, acc_nxt, pw_r, pw_nxt, bb_r, bb_nxt;
  logic [EW-1:0]        pe_r, pe_nxt;

  // result flags and fields
  logic                 ovf_r, ovf_nxt, full_r, full_nxt, bad_r, bad_nxt, rng_r, rng_nxt;
  logic signed [CW-1:0] oc_r, oc_nxt, val_r, val_nxt;
  logic [EW-1:0]        oe_r, oe_nxt;

  // output register
  logic                 ov_r, ov_nxt;
  logic signed [CW-1:0] q_c_r, q_c_nxt, q_v_r, q_v_nxt;
  logic [EW-1:0]        q_e_r, q_e_nxt;
  logic [NW-1:0]        q_n_r, q_n_nxt;
  logic                 q_o_r, q_o_nxt;
  logic [1:0]           q_s_r, q_s_nxt;

  // store and multiplier hookup
  logic                          mem_we;
  logic [spa_pkg::ADDR_W-1:0]    mem_waddr, mem_raddr;
  logic [spa_pkg::WORD_W-1:0]    mem_wdata, mem_rdata;
  logic signed [CW-1:0]          rd_c;
  logic [EW-1:0]                 rd_e;
  logic signed [CW-1:0]          mul_a, mul_b;
  spa_pkg::sat_t                 mul_res;

  // combinational helpers
  logic [NW-1:0]   cur_n;
  spa_pkg::sat_t   sum;
  logic [EW:0]     esum;
  logic            needs_tgt;
  logic            take_a, take_b;
  logic signed [CW-1:0] pick_c;
  logic [EW-1:0]   pick_e;

  spa_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  spa_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  assign rd_c = mem_rdata[spa_pkg::WORD_W-1:EW];
  assign rd_e = mem_rdata[EW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spa_pkg::S_IDLE;
      cnt_r   <= '{default: '0};
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;   tgt_r  <= tgt_nxt;   lst_r  <= lst_nxt;   x_r    <= x_nxt;
    i_r    <= i_nxt;     j_r    <= j_nxt;     k_r    <= k_nxt;
    s_r    <= s_nxt;     m_r    <= m_nxt;
    a_c_r  <= a_c_nxt;   a_e_r  <= a_e_nxt;   b_c_r  <= b_c_nxt;
    ac_c_r <= ac_c_nxt;  ac_e_r <= ac_e_nxt;
    acc_r  <= acc_nxt;   pw_r   <= pw_nxt;    bb_r   <= bb_nxt;    pe_r   <= pe_nxt;
    ovf_r  <= ovf_nxt;   full_r <= full_nxt;  bad_r  <= bad_nxt;   rng_r  <= rng_nxt;
    oc_r   <= oc_nxt;    oe_r   <= oe_nxt;    val_r  <= val_nxt;
    q_c_r  <= q_c_nxt;   q_e_r  <= q_e_nxt;   q_n_r  <= q_n_nxt;
    q_v_r  <= q_v_nxt;   q_o_r  <= q_o_nxt;   q_s_r  <= q_s_nxt;
  end

  assign cur_n = (lst_r == spa_pkg::LIST_FIRST)  ? cnt_r[0] :
                 (lst_r == spa_pkg::LIST_SECOND) ? cnt_r[1] : cnt_r[2];

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;   tgt_nxt = tgt_r;   lst_nxt = lst_r;   x_nxt = x_r;
    cnt_nxt = cnt_r;
    i_nxt = i_r;  j_nxt = j_r;  k_nxt = k_r;  s_nxt = s_r;  m_nxt = m_r;
    a_c_nxt = a_c_r;  a_e_nxt = a_e_r;  b_c_nxt = b_c_r;
    ac_c_nxt = ac_c_r;  ac_e_nxt = ac_e_r;
    acc_nxt = acc_r;  pw_nxt = pw_r;  bb_nxt = bb_r;  pe_nxt = pe_r;
    ovf_nxt = ovf_r;  full_nxt = full_r;  bad_nxt = bad_r;  rng_nxt = rng_r;
    oc_nxt = oc_r;  oe_nxt = oe_r;  val_nxt = val_r;
    ov_nxt = ov_r && !out_ready;
    q_c_nxt = q_c_r;  q_e_nxt = q_e_r;  q_n_nxt = q_n_r;
    q_v_nxt = q_v_r;  q_o_nxt = q_o_r;  q_s_nxt = q_s_r;
    mem_we = 1'b0;  mem_waddr = '0;  mem_wdata = '0;  mem_raddr = '0;
    mul_a = '0;  mul_b = '0;
    sum = '0;  esum = '0;
    take_a = 1'b0;  take_b = 1'b0;  pick_c = '0;  pick_e = '0;
    needs_tgt = (in_command == spa_pkg::CMD_CLEAR) || (in_command == spa_pkg::CMD_INSERT) ||
                (in_command == spa_pkg::CMD_EVAL);

    unique case (state_r)
      spa_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_command;  tgt_nxt = in_target;  x_nxt = in_point;
          ovf_nxt = 1'b0;  full_nxt = 1'b0;  bad_nxt = 1'b0;  rng_nxt = 1'b0;
          oc_nxt = '0;  oe_nxt = '0;  val_nxt = '0;  acc_nxt = '0;
          i_nxt = '0;  j_nxt = '0;  k_nxt = '0;  s_nxt = '0;
          state_nxt = spa_pkg::S_DONE;
          if (in_command > spa_pkg::CMD_EVAL || (needs_tgt && in_target == spa_pkg::LIST_NONE)) begin
            bad_nxt = 1'b1;
          end else begin
            unique case (in_command)
              spa_pkg::CMD_CLEAR: begin
                cnt_nxt[in_target] = '0;
              end
              spa_pkg::CMD_INSERT: begin
                ac_c_nxt = in_coefficient;
                ac_e_nxt = in_exponent;
                lst_nxt  = in_target;
                if (in_coefficient != '0) begin
                  state_nxt = spa_pkg::S_AC_SCAN;
                end
              end
              spa_pkg::CMD_ADD: begin
                state_nxt = spa_pkg::S_AD_TOP;
              end
              spa_pkg::CMD_MUL: begin
                lst_nxt   = spa_pkg::LIST_RESULT;
                cnt_nxt[2] = '0;
                state_nxt = spa_pkg::S_MU_TOP;
              end
              spa_pkg::CMD_READ: begin
                if (NW'(in_term_index) < cnt_r[2]) begin
                  mem_raddr = spa_pkg::mk_addr(spa_pkg::LIST_RESULT, NW'(in_term_index));
                  state_nxt = spa_pkg::S_RD_WAIT;
                end else begin
                  rng_nxt = 1'b1;
                end
              end
              spa_pkg::CMD_EVAL: begin
                lst_nxt   = in_target;
                state_nxt = spa_pkg::S_EV_TOP;
              end
              default: begin
                bad_nxt = 1'b1;
              end
            endcase
          end
        end
      end

      spa_pkg::S_RD_WAIT: begin
        oc_nxt = rd_c;
        oe_nxt = rd_e;
        state_nxt = spa_pkg::S_DONE;
      end

      // accumulate one term (ac_c, ac_e) into list lst, kept in descending order
      spa_pkg::S_AC_SCAN: begin
        if (s_r < cur_n) begin
          mem_raddr = spa_pkg::mk_addr(lst_r, s_r);
          state_nxt = spa_pkg::S_AC_CMP;
        end else begin
          state_nxt = spa_pkg::S_AC_INS;
        end
      end
      spa_pkg::S_AC_CMP: begin
        sum = spa_pkg::add_sat(rd_c, ac_c_r);
        if (rd_e > ac_e_r) begin
          s_nxt = s_r + NW'(1);
          state_nxt = spa_pkg::S_AC_SCAN;
        end else if (rd_e == ac_e_r) begin
          ovf_nxt = ovf_r | sum.ovf;
          if (sum.val == '0) begin
            m_nxt = s_r;
            state_nxt = spa_pkg::S_AC_DEL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = spa_pkg::mk_addr(lst_r, s_r);
            mem_wdata = {sum.val, rd_e};
            state_nxt = spa_pkg::S_AC_RET;
          end
        end else begin
          state_nxt = spa_pkg::S_AC_INS;
        end
      end
      spa_pkg::S_AC_INS: begin
        if (cur_n >= NW'(spa_pkg::MAX_TERMS)) begin
          full_nxt = 1'b1;
          state_nxt = spa_pkg::S_AC_RET;
        end else begin
          m_nxt = cur_n;
          state_nxt = spa_pkg::S_AC_UP;
        end
      end
      spa_pkg::S_AC_UP: begin
        if (m_r > s_r) begin
          mem_raddr = spa_pkg::mk_addr(lst_r, m_r - NW'(1));
          state_nxt = spa_pkg::S_AC_UPW;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = spa_pkg::mk_addr(lst_r, s_r);
          mem_wdata = {ac_c_r, ac_e_r};
          cnt_nxt[lst_r] = cur_n + NW'(1);
          state_nxt = spa_pkg::S_AC_RET;
        end
      end
      spa_pkg::S_AC_UPW: begin
        mem_we    = 1'b1;
        mem_waddr = spa_pkg::mk_addr(lst_r, m_r);
        mem_wdata = mem_rdata;
        m_nxt = m_r - NW'(1);
        state_nxt = spa_pkg::S_AC_UP;
      end
      spa_pkg::S_AC_DEL: begin
        if (m_r + NW'(1) < cur_n) begin
          mem_raddr = spa_pkg::mk_addr(lst_r, m_r + NW'(1));
          state_nxt = spa_pkg::S_AC_DELW;
        end else begin
          cnt_nxt[lst_r] = cur_n - NW'(1);
          state_nxt = spa_pkg::S_AC_RET;
        end
      end
      spa_pkg::S_AC_DELW: begin
        mem_we    = 1'b1;
        mem_waddr = spa_pkg::mk_addr(lst_r, m_r);
        mem_wdata = mem_rdata;
        m_nxt = m_r + NW'(1);
        state_nxt = spa_pkg::S_AC_DEL;
      end
      spa_pkg::S_AC_RET: begin
        state_nxt = (cmd_r == spa_pkg::CMD_MUL) ? spa_pkg::S_MU_NEXT : spa_pkg::S_DONE;
      end

      // merge first and second into result
      spa_pkg::S_AD_TOP: begin
        if (i_r >= cnt_r[0] && j_r >= cnt_r[1]) begin
          cnt_nxt[2] = k_r;
          state_nxt = spa_pkg::S_DONE;
        end else begin
          mem_raddr = spa_pkg::mk_addr(spa_pkg::LIST_FIRST, i_r);
          state_nxt = spa_pkg::S_AD_RA;
        end
      end
      spa_pkg::S_AD_RA: begin
        a_c_nxt = rd_c;
        a_e_nxt = rd_e;
        mem_raddr = spa_pkg::mk_addr(spa_pkg::LIST_SECOND, j_r);
        state_nxt = spa_pkg::S_AD_RB;
      end
      spa_pkg::S_AD_RB: begin
        take_a = (j_r >= cnt_r[1]) || (i_r < cnt_r[0] && a_e_r > rd_e);
        take_b = !take_a && ((i_r >= cnt_r[0]) || rd_e > a_e_r);
        sum = spa_pkg::add_sat(a_c_r, rd_c);
        if (take_a) begin
          pick_c = a_c_r;  pick_e = a_e_r;  i_nxt = i_r + NW'(1);
        end else if (take_b) begin
          pick_c = rd_c;   pick_e = rd_e;   j_nxt = j_r + NW'(1);
        end else begin
          pick_c = sum.val;  pick_e = a_e_r;
          ovf_nxt = ovf_r | sum.ovf;
          i_nxt = i_r + NW'(1);  j_nxt = j_r + NW'(1);
        end
        if (pick_c != '0) begin
          if (k_r >= NW'(spa_pkg::MAX_TERMS)) begin
            full_nxt = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = spa_pkg::mk_addr(spa_pkg::LIST_RESULT, k_r);
            mem_wdata = {pick_c, pick_e};
            k_nxt = k_r + NW'(1);
          end
        end
        state_nxt = spa_pkg::S_AD_TOP;
      end

      // every pair of terms, product accumulated into result unless the exponent sum overflows
      spa_pkg::S_MU_TOP: begin
        if (i_r >= cnt_r[0]) begin
          state_nxt = spa_pkg::S_DONE;
        end else if (j_r >= cnt_r[1]) begin
          i_nxt = i_r + NW'(1);
          j_nxt = '0;
        end else begin
          mem_raddr = spa_pkg::mk_addr(spa_pkg::LIST_FIRST, i_r);
          state_nxt = spa_pkg::S_MU_RA;
        end
      end
      spa_pkg::S_MU_RA: begin
        a_c_nxt = rd_c;
        a_e_nxt = rd_e;
        mem_raddr = spa_pkg::mk_addr(spa_pkg::LIST_SECOND, j_r);
        state_nxt = spa_pkg::S_MU_RB;
      end
      spa_pkg::S_MU_RB: begin
        esum = {1'b0, a_e_r} + {1'b0, rd_e};
        b_c_nxt = rd_c;
        ac_e_nxt = esum[EW-1:0];
        if (esum[EW]) begin
          ovf_nxt = 1'b1;
          state_nxt = spa_pkg::S_MU_NEXT;
        end else begin
          state_nxt = spa_pkg::S_MU_MUL;
        end
      end
      spa_pkg::S_MU_MUL: begin
        mul_a = a_c_r;
        mul_b = b_c_r;
        state_nxt = spa_pkg::S_MU_SAT;
      end
      spa_pkg::S_MU_SAT: begin
        ovf_nxt  = ovf_r | mul_res.ovf;
        ac_c_nxt = mul_res.val;
        s_nxt    = '0;
        state_nxt = (mul_res.val == '0) ? spa_pkg::S_MU_NEXT : spa_pkg::S_AC_SCAN;
      end
      spa_pkg::S_MU_NEXT: begin
        j_nxt = j_r + NW'(1);
        state_nxt = spa_pkg::S_MU_TOP;
      end

      // evaluate: sum of c * x^e, power by square-and-multiply
      spa_pkg::S_EV_TOP: begin
        if (i_r >= cur_n) begin
          val_nxt = acc_r;
          state_nxt = spa_pkg::S_DONE;
        end else begin
          mem_raddr = spa_pkg::mk_addr(lst_r, i_r);
          state_nxt = spa_pkg::S_EV_LD;
        end
      end
      spa_pkg::S_EV_LD: begin
        a_c_nxt = rd_c;
        pe_nxt  = rd_e;
        pw_nxt  = spa_pkg::C_ONE;
        bb_nxt  = x_r;
        state_nxt = spa_pkg::S_EV_BIT;
      end
      spa_pkg::S_EV_BIT: begin
        if (pe_r == '0) begin
          state_nxt = spa_pkg::S_EV_TMUL;
        end else if (pe_r[0]) begin
          state_nxt = spa_pkg::S_EV_RMUL;
        end else begin
          state_nxt = spa_pkg::S_EV_SHIFT;
        end
      end
      spa_pkg::S_EV_RMUL: begin
        mul_a = pw_r;
        mul_b = bb_r;
        state_nxt = spa_pkg::S_EV_RSAT;
      end
      spa_pkg::S_EV_RSAT: begin
        pw_nxt  = mul_res.val;
        ovf_nxt = ovf_r | mul_res.ovf;
        state_nxt = spa_pkg::S_EV_SHIFT;
      end
      spa_pkg::S_EV_SHIFT: begin
        pe_nxt = pe_r >> 1;
        state_nxt = ((pe_r >> 1) != '0) ? spa_pkg::S_EV_BMUL : spa_pkg::S_EV_BIT;
      end
      spa_pkg::S_EV_BMUL: begin
        mul_a = bb_r;
        mul_b = bb_r;
        state_nxt = spa_pkg::S_EV_BSAT;
      end
      spa_pkg::S_EV_BSAT: begin
        bb_nxt  = mul_res.val;
        ovf_nxt = ovf_r | mul_res.ovf;
        state_nxt = spa_pkg::S_EV_BIT;
      end
      spa_pkg::S_EV_TMUL: begin
        mul_a = a_c_r;
        mul_b = pw_r;
        state_nxt = spa_pkg::S_EV_TSAT;
      end
      spa_pkg::S_EV_TSAT: begin
        sum = spa_pkg::add_sat(acc_r, mul_res.val);
        acc_nxt = sum.val;
        ovf_nxt = ovf_r | mul_res.ovf | sum.ovf;
        i_nxt = i_r + NW'(1);
        state_nxt = spa_pkg::S_EV_TOP;
      end

      // hand the finished request to the output register once it is free
      spa_pkg::S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt  = 1'b1;
          q_c_nxt = oc_r;
          q_e_nxt = oe_r;
          q_v_nxt = val_r;
          q_o_nxt = ovf_r;
          if (bad_r) begin
            q_n_nxt = '0;
            q_s_nxt = spa_pkg::ST_BAD;
          end else begin
            if (cmd_r == spa_pkg::CMD_ADD || cmd_r == spa_pkg::CMD_MUL ||
                cmd_r == spa_pkg::CMD_READ) begin
              q_n_nxt = cnt_r[2];
            end else begin
              q_n_nxt = cnt_r[tgt_r];
            end
            q_s_nxt = rng_r ? spa_pkg::ST_RANGE :
                      (full_r ? spa_pkg::ST_FULL : spa_pkg::ST_OK);
          end
          state_nxt = spa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = spa_pkg::S_IDLE;
      end
    endcase
  end

  assign in_ready        = (state_r == spa_pkg::S_IDLE);
  assign out_valid       = ov_r;
  assign out_coefficient = q_c_r;
  assign out_exponent    = q_e_r;
  assign out_term_count  = q_n_r;
  assign out_value       = q_v_r;
  assign out_overflow    = q_o_r;
  assign out_status      = q_s_r;

endmodule
`default_nettype wire

/* rtl/core/spa_chk.sv */
// Port-level checker for the sparse polynomial unit, bound to the top level.
`default_nettype none
module spa_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [spa_pkg::COEF_W-1:0] out_coefficient,
  input wire logic [spa_pkg::EXP_W-1:0]         out_exponent,
  input wire logic [spa_pkg::CNT_W-1:0]         out_term_count,
  input wire logic signed [spa_pkg::COEF_W-1:0] out_value,
  input wire logic [1:0]                        out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_coefficient) && $stable(out_status))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spa_pkg::ST_BAD |-> out_term_count == '0 && out_value == '0)
    else $error("bad command reported data");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spa_pkg::ST_RANGE |-> out_coefficient == '0 &&
    out_exponent == '0)
    else $error("out of range read returned a term");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_term_count <= spa_pkg::CNT_W'(spa_pkg::MAX_TERMS))
    else $error("term count above capacity");

endmodule

bind sparse_polynomial_arithmetic spa_chk u_spa_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_coefficient (out_coefficient),
  .out_exponent    (out_exponent),
  .out_term_count  (out_term_count),
  .out_value       (out_value),
  .out_status      (out_status)
);
`default_nettype wire

/* verif/sparse_polynomial_arithmetic_tb.sv */
// Self-checking testbench for the sparse polynomial arithmetic unit.
`default_nettype none
module sparse_polynomial_arithmetic_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  RAND_ITEMS  = 850;
  localparam int  CALM_ITEMS  = 100;
  localparam int  SMALL_LIST  = 6;
  localparam int  SCRATCH     = 3;
  localparam int  CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [spa_pkg::COEF_W-1:0] coef;
    logic [spa_pkg::EXP_W-1:0]  expo;
    logic [spa_pkg::CNT_W-1:0]  count;
    logic [spa_pkg::COEF_W-1:0] value;
    logic                       ovf;
    logic [1:0]                 status;
  } term_result_t;

  typedef struct packed {
    logic [2:0]                 cmd;
    logic [1:0]                 tgt;
    logic [spa_pkg::COEF_W-1:0] coef;
    logic [spa_pkg::EXP_W-1:0]  expo;
    logic [spa_pkg::IDX_W-1:0]  idx;
    logic [spa_pkg::COEF_W-1:0] point;
    logic                       fixed;
    term_result_t               res;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_command = '0;
  logic [1:0] in_target = '0;
  logic signed [spa_pkg::COEF_W-1:0] in_coefficient = '0;
  logic [spa_pkg::EXP_W-1:0] in_exponent = '0;
  logic [spa_pkg::IDX_W-1:0] in_term_index = '0;
  logic signed [spa_pkg::COEF_W-1:0] in_point = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [spa_pkg::COEF_W-1:0] out_coefficient;
  logic [spa_pkg::EXP_W-1:0] out_exponent;
  logic [spa_pkg::CNT_W-1:0] out_term_count;
  logic signed [spa_pkg::COEF_W-1:0] out_value;
  logic out_overflow;
  logic [1:0] out_status;

  sparse_polynomial_arithmetic dut (.*);

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the three lists; slot SCRATCH builds add and multiply results.
  longint poly_c [4][spa_pkg::MAX_TERMS];
  int     poly_e [4][spa_pkg::MAX_TERMS];
  int     poly_n [4];
  bit     sat_seen, cap_hit;

  term_result_t pending_results[$];
  term_result_t fixed_res;
  logic         fixed_flag = 1'b0;
  int  n_accepted = 0, n_checked = 0, n_mismatch = 0, cycles = 0;
  bit  calm = 1'b0;
  int  stall_left = 0;

  function automatic longint clamp_coef(longint v);
    if (v > longint'(spa_pkg::C_HI)) begin
      sat_seen = 1'b1;
      return longint'(spa_pkg::C_HI);
    end
    if (v < longint'(spa_pkg::C_LO)) begin
      sat_seen = 1'b1;
      return longint'(spa_pkg::C_LO);
    end
    return v;
  endfunction

  // Products fit in 64 bits; truncate the magnitude, not the signed value.
  function automatic longint q16_mul(longint a, longint b);
    longint p, q;
    p = a * b;
    q = (p < 0) ? -p : p;
    q = q >> spa_pkg::FRAC_W;
    return clamp_coef((p < 0) ? -q : q);
  endfunction

  function automatic longint x_pow(longint x, int e);
    longint r, b;
    r = longint'(spa_pkg::C_ONE);
    b = x;
    while (e != 0) begin
      if (e[0]) r = q16_mul(r, b);
      e = e >> 1;
      if (e != 0) b = q16_mul(b, b);
    end
    return r;
  endfunction

  // Add a term into list l in exponent order; a zero sum removes the term.
  function automatic void merge_term(int l, longint c, int e);
    int i;
    longint s;
    i = 0;
    if (c == 0) return;
    while (i < poly_n[l] && poly_e[l][i] > e) i++;
    if (i < poly_n[l] && poly_e[l][i] == e) begin
      s = clamp_coef(poly_c[l][i] + c);
      if (s == 0) begin
        for (int k = i; k < poly_n[l] - 1; k++) begin
          poly_c[l][k] = poly_c[l][k+1];
          poly_e[l][k] = poly_e[l][k+1];
        end
        poly_n[l]--;
      end else begin
        poly_c[l][i] = s;
      end
      return;
    end
    if (poly_n[l] >= spa_pkg::MAX_TERMS) begin
      cap_hit = 1'b1;
      return;
    end
    for (int k = poly_n[l]; k > i; k--) begin
      poly_c[l][k] = poly_c[l][k-1];
      poly_e[l][k] = poly_e[l][k-1];
    end
    poly_c[l][i] = c;
    poly_e[l][i] = e;
    poly_n[l]++;
  endfunction

  function automatic term_result_t predict_result(request_t rq);
    term_result_t r;
    int i, j, e;
    longint c, acc, x;
    r = '0;
    sat_seen = 1'b0;
    cap_hit = 1'b0;
    if (rq.cmd > spa_pkg::CMD_EVAL ||
        ((rq.cmd == spa_pkg::CMD_CLEAR || rq.cmd == spa_pkg::CMD_INSERT ||
          rq.cmd == spa_pkg::CMD_EVAL) && rq.tgt == spa_pkg::LIST_NONE)) begin
      r.status = spa_pkg::ST_BAD;
      return r;
    end
    case (rq.cmd)
      spa_pkg::CMD_CLEAR: begin
        poly_n[rq.tgt] = 0;
      end
      spa_pkg::CMD_INSERT: begin
        merge_term(rq.tgt, longint'($signed(rq.coef)), int'(rq.expo));
        r.count = spa_pkg::CNT_W'(poly_n[rq.tgt]);
      end
      spa_pkg::CMD_ADD: begin
        i = 0; j = 0;
        poly_n[SCRATCH] = 0;
        while (i < poly_n[spa_pkg::LIST_FIRST] || j < poly_n[spa_pkg::LIST_SECOND]) begin
          if (j >= poly_n[spa_pkg::LIST_SECOND] || (i < poly_n[spa_pkg::LIST_FIRST] &&
              poly_e[spa_pkg::LIST_FIRST][i] > poly_e[spa_pkg::LIST_SECOND][j])) begin
            c = poly_c[spa_pkg::LIST_FIRST][i]; e = poly_e[spa_pkg::LIST_FIRST][i]; i++;
          end else if (i >= poly_n[spa_pkg::LIST_FIRST] ||
                       poly_e[spa_pkg::LIST_SECOND][j] > poly_e[spa_pkg::LIST_FIRST][i]) begin
            c = poly_c[spa_pkg::LIST_SECOND][j]; e = poly_e[spa_pkg::LIST_SECOND][j]; j++;
          end else begin
            c = clamp_coef(poly_c[spa_pkg::LIST_FIRST][i] + poly_c[spa_pkg::LIST_SECOND][j]);
            e = poly_e[spa_pkg::LIST_FIRST][i]; i++; j++;
          end
          if (c == 0) continue;
          if (poly_n[SCRATCH] >= spa_pkg::MAX_TERMS) begin
            cap_hit = 1'b1;
            continue;
          end
          poly_c[SCRATCH][poly_n[SCRATCH]] = c;
          poly_e[SCRATCH][poly_n[SCRATCH]] = e;
          poly_n[SCRATCH]++;
        end
        poly_c[spa_pkg::LIST_RESULT] = poly_c[SCRATCH];
        poly_e[spa_pkg::LIST_RESULT] = poly_e[SCRATCH];
        poly_n[spa_pkg::LIST_RESULT] = poly_n[SCRATCH];
        r.count = spa_pkg::CNT_W'(poly_n[spa_pkg::LIST_RESULT]);
      end
      spa_pkg::CMD_MUL: begin
        poly_n[SCRATCH] = 0;
        for (i = 0; i < poly_n[spa_pkg::LIST_FIRST]; i++)
          for (j = 0; j < poly_n[spa_pkg::LIST_SECOND]; j++) begin
            e = poly_e[spa_pkg::LIST_FIRST][i] + poly_e[spa_pkg::LIST_SECOND][j];
            if (e > (1 << spa_pkg::EXP_W) - 1) begin
              sat_seen = 1'b1;
              continue;
            end
            merge_term(SCRATCH, q16_mul(poly_c[spa_pkg::LIST_FIRST][i],
                                        poly_c[spa_pkg::LIST_SECOND][j]), e);
          end
        poly_c[spa_pkg::LIST_RESULT] = poly_c[SCRATCH];
        poly_e[spa_pkg::LIST_RESULT] = poly_e[SCRATCH];
        poly_n[spa_pkg::LIST_RESULT] = poly_n[SCRATCH];
        r.count = spa_pkg::CNT_W'(poly_n[spa_pkg::LIST_RESULT]);
      end
      spa_pkg::CMD_READ: begin
        r.count = spa_pkg::CNT_W'(poly_n[spa_pkg::LIST_RESULT]);
        if (int'(rq.idx) < poly_n[spa_pkg::LIST_RESULT]) begin
          r.coef = poly_c[spa_pkg::LIST_RESULT][rq.idx][spa_pkg::COEF_W-1:0];
          r.expo = poly_e[spa_pkg::LIST_RESULT][rq.idx][spa_pkg::EXP_W-1:0];
        end else begin
          r.status = spa_pkg::ST_RANGE;
        end
      end
      default: begin
        x = longint'($signed(rq.point));
        acc = 0;
        for (i = 0; i < poly_n[rq.tgt]; i++)
          acc = clamp_coef(acc + q16_mul(poly_c[rq.tgt][i], x_pow(x, poly_e[rq.tgt][i])));
        r.value = acc[spa_pkg::COEF_W-1:0];
        r.count = spa_pkg::CNT_W'(poly_n[rq.tgt]);
      end
    endcase
    r.ovf = sat_seen;
    if (cap_hit && r.status == spa_pkg::ST_OK) r.status = spa_pkg::ST_FULL;
    return r;
  endfunction

  function automatic void check_field(string name, logic [spa_pkg::COEF_W-1:0] want,
                                      logic [spa_pkg::COEF_W-1:0] got, inout bit bad);
    if (want !== got) begin
      bad = 1'b1;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // Predict on every accepted request; compare every accepted result.
  always @(posedge clk) begin
    term_result_t w;
    bit bad;
    cycles <= cycles + 1;
    if (rst_n && in_valid && in_ready) begin
      w = predict_result('{in_command, in_target, in_coefficient, in_exponent,
                           in_term_index, in_point, 1'b0, '0});
      pending_results.push_back(fixed_flag ? fixed_res : w);
      n_accepted <= n_accepted + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      bad = 1'b0;
      if (pending_results.size() == 0) begin
        bad = 1'b1;
        $error("result with no request outstanding");
      end else begin
        w = pending_results.pop_front();
        check_field("coefficient", w.coef, out_coefficient, bad);
        check_field("exponent", w.expo, out_exponent, bad);
        check_field("term_count", w.count, out_term_count, bad);
        check_field("value", w.value, out_value, bad);
        check_field("overflow", w.ovf, out_overflow, bad);
        check_field("status", w.status, out_status, bad);
      end
      if (bad) n_mismatch <= n_mismatch + 1;
      n_checked <= n_checked + 1;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side back-pressure in random bursts; none once the run goes calm.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && rst_n && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one request at a falling edge and hold it until it is taken.
  task automatic send_request(request_t rq);
    int seen;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_command = rq.cmd;
    in_target = rq.tgt;
    in_coefficient = rq.coef;
    in_exponent = rq.expo;
    in_term_index = rq.idx;
    in_point = rq.point;
    fixed_flag = rq.fixed;
    fixed_res = rq.res;
    in_valid = 1'b1;
    seen = n_accepted;
    do @(negedge clk); while (n_accepted == seen);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Directed table: fixed results only where they are obvious.
  request_t directed [] = '{
    '{spa_pkg::CMD_READ, spa_pkg::LIST_FIRST, 32'h0, 8'h0, 6'd0, 32'h0, 1'b1,
      '{0, 0, 0, 0, 0, spa_pkg::ST_RANGE}},
    '{3'd6, spa_pkg::LIST_FIRST, 32'h0, 8'h0, 6'd0, 32'h0, 1'b1,
      '{0, 0, 0, 0, 0, spa_pkg::ST_BAD}},
    '{3'd7, spa_pkg::LIST_RESULT, 32'hFFFFFFFF, 8'hFF, 6'd63, 32'hFFFFFFFF, 1'b1,
      '{0, 0, 0, 0, 0, spa_pkg::ST_BAD}},
    '{spa_pkg::CMD_CLEAR, spa_pkg::LIST_NONE, 32'h0, 8'h0, 6'd0, 32'h0, 1'b1,
      '{0, 0, 0, 0, 0, spa_pkg::ST_BAD}},
    '{spa_pkg::CMD_INSERT, spa_pkg::LIST_NONE, 32'h10000, 8'h3, 6'd0, 32'h0, 1'b1,
      '{0, 0, 0, 0, 0, spa_pkg::ST_BAD}},
    '{spa_pkg::CMD_EVAL, spa_pkg::LIST_NONE, 32'h0, 8'h0, 6'd0, 32'h10000, 1'b1,
      '{0, 0, 0, 0, 0, spa_pkg::ST_BAD}},
    '{spa_pkg::CMD_EVAL, spa_pkg::LIST_FIRST, 32'h0, 8'h0, 6'd0, 32'h10000, 1'b1,
      '{0, 0, 0, 0, 0, spa_pkg::ST_OK}},
    '{spa_pkg::CMD_INSERT, spa_pkg::LIST_FIRST, 32'h0, 8'h5, 6'd0, 32'h0, 1'b1,
      '{0, 0, 0, 0, 0, spa_pkg::ST_OK}},
    '{spa_pkg::CMD_INSERT, spa_pkg::LIST_FIRST, 32'h7FFFFFFF, 8'hFF, 6'd0, 32'h0, 1'b1,
      '{0, 0, 1, 0, 0, spa_pkg::ST_OK}},
    '{spa_pkg::CMD_INSERT, spa_pkg::LIST_FIRST, 32'h80000000, 8'h0, 6'd0, 32'h0, 1'b1,
      '{0, 0, 2, 0, 0, spa_pkg::ST_OK}},
    '{spa_pkg::CMD_INSERT, spa_pkg::LIST_FIRST, 32'h10000, 8'hFF, 6'd0, 32'h0, 1'b1,
      '{0, 0, 2, 0, 1, spa_pkg::ST_OK}},
    '{spa_pkg::CMD_INSERT, spa_pkg::LIST_SECOND, 32'h10000, 8'h1, 6'd0, 32'h0, 1'b0, '0},
    '{spa_pkg::CMD_INSERT, spa_pkg::LIST_SECOND, 32'hFFFF0000, 8'h0, 6'd0, 32'h0, 1'b0, '0},
    '{spa_pkg::CMD_INSERT, spa_pkg::LIST_SECOND, 32'h20000, 8'hFF, 6'd0, 32'h0, 1'b0, '0},
    '{spa_pkg::CMD_ADD, spa_pkg::LIST_NONE, 32'h0, 8'h0, 6'd0, 32'h0, 1'b0, '0},
    '{spa_pkg::CMD_READ, spa_pkg::LIST_FIRST, 32'h0, 8'h0, 6'd0, 32'h0, 1'b0, '0},
    '{spa_pkg::CMD_READ, spa_pkg::LIST_FIRST, 32'h0, 8'h0, 6'd63, 32'h0, 1'b0, '0},
    '{spa_pkg::CMD_MUL, spa_pkg::LIST_SECOND, 32'h0, 8'h0, 6'd0, 32'h0, 1'b0, '0},
    '{spa_pkg::CMD_EVAL, spa_pkg::LIST_FIRST, 32'h0, 8'h0, 6'd0, 32'h20000, 1'b0, '0},
    '{spa_pkg::CMD_EVAL, spa_pkg::LIST_SECOND, 32'h0, 8'h0, 6'd0, 32'h80000000, 1'b0, '0},
    '{spa_pkg::CMD_EVAL, spa_pkg::LIST_RESULT, 32'h0, 8'h0, 6'd0, 32'h7FFFFFFF, 1'b0, '0},
    '{spa_pkg::CMD_INSERT, spa_pkg::LIST_SECOND, 32'hFFFF0000, 8'h1, 6'd0, 32'h0, 1'b0, '0},
    '{spa_pkg::CMD_CLEAR, spa_pkg::LIST_RESULT, 32'h0, 8'h0, 6'd0, 32'h0, 1'b1,
      '{0, 0, 0, 0, 0, spa_pkg::ST_OK}},
    '{spa_pkg::CMD_INSERT, spa_pkg::LIST_RESULT, 32'h12345678, 8'h5A, 6'd0, 32'h0, 1'b0, '0},
    '{spa_pkg::CMD_READ, spa_pkg::LIST_NONE, 32'h0, 8'h0, 6'd0, 32'h0, 1'b0, '0}
  };

  initial begin
    request_t rq;
    int sel, t;
    poly_n = '{0, 0, 0, 0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[k]) send_request(directed[k]);

    // Fill both operands to capacity, overrun one, and overrun the result by add.
    rq = '0;
    rq.cmd = spa_pkg::CMD_CLEAR; rq.tgt = spa_pkg::LIST_FIRST;  send_request(rq);
    rq.tgt = spa_pkg::LIST_SECOND; send_request(rq);
    rq.cmd = spa_pkg::CMD_INSERT;
    for (int k = 0; k < 2 * spa_pkg::MAX_TERMS; k++) begin
      rq.tgt = (k < spa_pkg::MAX_TERMS) ? spa_pkg::LIST_FIRST : spa_pkg::LIST_SECOND;
      rq.expo = spa_pkg::EXP_W'(4 * (k % spa_pkg::MAX_TERMS) + (k / spa_pkg::MAX_TERMS));
      rq.coef = $urandom | 32'h1;
      send_request(rq);
    end
    rq.tgt = spa_pkg::LIST_FIRST; rq.expo = 8'd3; send_request(rq);
    rq.cmd = spa_pkg::CMD_ADD; send_request(rq);
    rq.cmd = spa_pkg::CMD_READ; rq.idx = spa_pkg::IDX_W'(spa_pkg::MAX_TERMS - 1);
    send_request(rq);
    rq.cmd = spa_pkg::CMD_EVAL; rq.point = spa_pkg::C_ONE; send_request(rq);
    rq.cmd = spa_pkg::CMD_CLEAR; send_request(rq);
    rq.tgt = spa_pkg::LIST_SECOND; send_request(rq);

    // Hold the sender until every result is back before the random part.
    drain_results();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= RAND_ITEMS - CALM_ITEMS);
      rq.coef = $urandom;
      rq.expo = spa_pkg::EXP_W'($urandom);
      rq.idx = spa_pkg::IDX_W'($urandom);
      rq.point = $urandom;
      rq.fixed = 1'b0;
      rq.tgt = 2'($urandom_range(0, 2));
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        rq.cmd = (poly_n[rq.tgt] >= SMALL_LIST) ? spa_pkg::CMD_CLEAR : spa_pkg::CMD_INSERT;
        if ($urandom_range(0, 3) == 0)
          rq.coef = $signed($urandom_range(0, 8) - 4) <<< spa_pkg::FRAC_W;
        if ($urandom_range(0, 1) == 0) rq.expo = spa_pkg::EXP_W'($urandom_range(0, 15));
      end else if (sel < 52) begin
        rq.cmd = spa_pkg::CMD_CLEAR;
      end else if (sel < 64) begin
        rq.cmd = spa_pkg::CMD_ADD;
      end else if (sel < 72) begin
        rq.cmd = spa_pkg::CMD_MUL;
      end else if (sel < 84) begin
        rq.cmd = spa_pkg::CMD_READ;
        if ($urandom_range(0, 3) != 0)
          rq.idx = spa_pkg::IDX_W'($urandom_range(0, poly_n[spa_pkg::LIST_RESULT]));
      end else if (sel < 95) begin
        rq.cmd = spa_pkg::CMD_EVAL;
        if ($urandom_range(0, 1) == 0) rq.point = $signed($urandom_range(0, 6) - 3) <<< 15;
      end else begin
        // Malformed requests: unused opcodes or a missing target.
        t = $urandom_range(0, 4);
        rq.cmd = (t == 0) ? 3'd6 : (t == 1) ? 3'd7 : (t == 2) ? spa_pkg::CMD_CLEAR :
                 (t == 3) ? spa_pkg::CMD_INSERT : spa_pkg::CMD_EVAL;
        if (t >= 2) rq.tgt = spa_pkg::LIST_NONE;
      end
      send_request(rq);
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d requests with %0d results compared over %0d cycles",
             n_accepted, n_checked, cycles);
    $display("directed table, capacity overrun and random mixed traffic with stalls");
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/core/spa_pkg.sv
rtl/core/spa_mem.sv
rtl/core/spa_mul.sv
rtl/core/sparse_polynomial_arithmetic.sv
rtl/core/spa_chk.sv
verif/sparse_polynomial_arithmetic_tb.sv
